// File: rtl/crc8pre_pkg.sv
`default_nettype none

package crc8pre_pkg;

    localparam int unsigned PAYLOAD_DEPTH = 256;
    localparam int unsigned PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

    localparam logic [7:0]  PREAMBLE      = 8'hFF;
    localparam logic [7:0]  CRC_INIT      = 8'hFF;
    localparam logic [7:0]  TYPE_RAISE    = 8'h80;
    localparam logic [8:0]  HDR_LEN       = 9'd4;
    localparam logic [7:0]  POLY_RESET    = 8'h31;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    localparam int unsigned CFG_DW = 16;

    typedef enum logic [0:0] {
        CFG_CRC_POLY      = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_RX_BYTE = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_OVERRUN = 2'd2,
        KIND_TX_RDY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_TX       = 3'd0,
        EV_OK       = 3'd1,
        EV_CRC      = 3'd2,
        EV_TIMEOUT  = 3'd3,
        EV_OVERRUN  = 3'd4,
        EV_BUSY     = 3'd5
    } t_event;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] tx_data;
        logic       tx_last;
    } t_out_item;

    // msb-first crc8 over one byte
    function automatic logic [7:0] crc8_step(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] v;
        v = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/crc8_packet_receive_echo_core.sv
// channel   | valid/ready              | payload
// ----------+--------------------------+-----------------------------
// input     | i_in_valid / o_in_ready  | i_in  (kind, rx_byte)
// output    | o_out_valid / i_out_ready| o_out (event_res, tx_data, tx_last)
// config    | i_cfg_we (no ready)      | i_cfg_idx, i_cfg_wdata
//
// one beat accepted per cycle while o_in_ready is high; its result, if any, is in the output register next cycle
// the payload memory is read every cycle at the echo index that follows the current beat
// so the registered read data is ready when the next tx beat comes
// reset is synchronous and active low; no clearing pass is needed
// the input stalls only while a result waits and the output side is not ready
`default_nettype none

module crc8_packet_receive_echo_core (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  crc8pre_pkg::t_in_item      i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output crc8pre_pkg::t_out_item     o_out,
    input  wire                        i_cfg_we,
    input  wire  [0:0]                 i_cfg_idx,
    input  wire  [crc8pre_pkg::CFG_DW-1:0] i_cfg_wdata
);

    logic [7:0]  r_crc_poly;
    logic [15:0] r_timeout_ticks;

    logic        r_receiving,    n_receiving;
    logic [8:0]  r_rx_count,     n_rx_count;
    logic [7:0]  r_hdr_counter,  n_hdr_counter;
    logic [7:0]  r_hdr_type,     n_hdr_type;
    logic [7:0]  r_hdr_length,   n_hdr_length;
    logic [7:0]  r_rx_crc,       n_rx_crc;
    logic [15:0] r_time_left,    n_time_left;
    logic        r_echo_pending, n_echo_pending;
    logic [8:0]  r_tx_index,     n_tx_index;
    logic [7:0]  r_tx_crc,       n_tx_crc;

    logic        r_out_valid;
    crc8pre_pkg::t_out_item r_out;

    logic [7:0]  mem [crc8pre_pkg::PAYLOAD_DEPTH];
    logic [7:0]  r_rd_data;

    logic        in_fire;
    logic        res_valid;
    crc8pre_pkg::t_out_item res;
    logic        mem_we;
    logic [crc8pre_pkg::PAYLOAD_AW-1:0] wr_addr;
    logic [crc8pre_pkg::PAYLOAD_AW-1:0] rd_addr;
    logic [8:0]  end_cnt;
    logic [8:0]  rx_idx;
    logic [8:0]  rd_idx;
    logic [7:0]  tx_byte;
    logic [7:0]  b;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign b       = i_in.rx_byte;
    assign end_cnt = {1'b0, r_hdr_length} + crc8pre_pkg::HDR_LEN;
    assign rx_idx  = r_rx_count - crc8pre_pkg::HDR_LEN;
    assign wr_addr = rx_idx[crc8pre_pkg::PAYLOAD_AW-1:0];
    assign rd_idx  = n_tx_index - crc8pre_pkg::HDR_LEN;
    assign rd_addr = rd_idx[crc8pre_pkg::PAYLOAD_AW-1:0];

    always_comb begin
        unique case (r_tx_index)
            9'd0:    tx_byte = crc8pre_pkg::PREAMBLE;
            9'd1:    tx_byte = r_hdr_counter;
            9'd2:    tx_byte = r_hdr_type + crc8pre_pkg::TYPE_RAISE;
            9'd3:    tx_byte = r_hdr_length;
            default: tx_byte = r_rd_data;
        endcase
    end

    always_comb begin
        n_receiving    = r_receiving;
        n_rx_count     = r_rx_count;
        n_hdr_counter  = r_hdr_counter;
        n_hdr_type     = r_hdr_type;
        n_hdr_length   = r_hdr_length;
        n_rx_crc       = r_rx_crc;
        n_time_left    = r_time_left;
        n_echo_pending = r_echo_pending;
        n_tx_index     = r_tx_index;
        n_tx_crc       = r_tx_crc;
        res_valid      = 1'b0;
        res            = '{event_res: crc8pre_pkg::EV_TX, tx_data: 8'd0, tx_last: 1'b0};
        mem_we         = 1'b0;

        if (in_fire) begin
            unique case (i_in.kind)
                crc8pre_pkg::KIND_RX_BYTE: begin
                    if (r_echo_pending) begin
                        res_valid     = 1'b1;
                        res.event_res = crc8pre_pkg::EV_BUSY;
                    end else if (!r_receiving) begin
                        if (b == crc8pre_pkg::PREAMBLE) begin
                            n_receiving = 1'b1;
                            n_rx_crc    = crc8pre_pkg::crc8_step(crc8pre_pkg::CRC_INIT, b,
                                                                 r_crc_poly);
                            n_rx_count  = 9'd1;
                            n_time_left = r_timeout_ticks;
                        end
                    end else if (r_rx_count >= crc8pre_pkg::HDR_LEN &&
                                 r_rx_count >= end_cnt) begin
                        // crc byte closes the packet
                        n_receiving = 1'b0;
                        n_rx_count  = 9'd0;
                        n_rx_crc    = crc8pre_pkg::CRC_INIT;
                        n_time_left = 16'd0;
                        res_valid   = 1'b1;
                        if (b == r_rx_crc) begin
                            res.event_res  = crc8pre_pkg::EV_OK;
                            n_echo_pending = 1'b1;
                            n_tx_index     = 9'd0;
                            n_tx_crc       = crc8pre_pkg::CRC_INIT;
                        end else begin
                            res.event_res = crc8pre_pkg::EV_CRC;
                        end
                    end else begin
                        priority if (r_rx_count == 9'd1) begin
                            n_hdr_counter = b;
                        end else if (r_rx_count == 9'd2) begin
                            n_hdr_type = b;
                        end else if (r_rx_count == 9'd3) begin
                            n_hdr_length = b;
                        end else begin
                            mem_we = 1'b1;
                        end
                        n_rx_crc   = crc8pre_pkg::crc8_step(r_rx_crc, b, r_crc_poly);
                        n_rx_count = r_rx_count + 9'd1;
                    end
                end
                crc8pre_pkg::KIND_TICK: begin
                    if (r_receiving) begin
                        if (r_time_left <= 16'd1) begin
                            n_receiving   = 1'b0;
                            n_rx_count    = 9'd0;
                            n_rx_crc      = crc8pre_pkg::CRC_INIT;
                            n_time_left   = 16'd0;
                            res_valid     = 1'b1;
                            res.event_res = crc8pre_pkg::EV_TIMEOUT;
                        end else begin
                            n_time_left = r_time_left - 16'd1;
                        end
                    end
                end
                crc8pre_pkg::KIND_OVERRUN: begin
                    n_receiving   = 1'b0;
                    n_rx_count    = 9'd0;
                    n_rx_crc      = crc8pre_pkg::CRC_INIT;
                    n_time_left   = 16'd0;
                    res_valid     = 1'b1;
                    res.event_res = crc8pre_pkg::EV_OVERRUN;
                end
                crc8pre_pkg::KIND_TX_RDY: begin
                    if (r_echo_pending) begin
                        res_valid = 1'b1;
                        if (r_tx_index >= end_cnt) begin
                            res.tx_data    = r_tx_crc;
                            res.tx_last    = 1'b1;
                            n_echo_pending = 1'b0;
                            n_tx_index     = 9'd0;
                            n_tx_crc       = crc8pre_pkg::CRC_INIT;
                        end else begin
                            res.tx_data = tx_byte;
                            n_tx_crc    = crc8pre_pkg::crc8_step(r_tx_crc, tx_byte,
                                                                 r_crc_poly);
                            n_tx_index  = r_tx_index + 9'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= b;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_poly      <= crc8pre_pkg::POLY_RESET;
            r_timeout_ticks <= crc8pre_pkg::TIMEOUT_RESET;
            r_receiving     <= 1'b0;
            r_rx_count      <= 9'd0;
            r_hdr_counter   <= 8'd0;
            r_hdr_type      <= 8'd0;
            r_hdr_length    <= 8'd0;
            r_rx_crc        <= crc8pre_pkg::CRC_INIT;
            r_time_left     <= 16'd0;
            r_echo_pending  <= 1'b0;
            r_tx_index      <= 9'd0;
            r_tx_crc        <= crc8pre_pkg::CRC_INIT;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (crc8pre_pkg::t_cfg_idx'(i_cfg_idx))
                    crc8pre_pkg::CFG_CRC_POLY:      r_crc_poly      <= i_cfg_wdata[7:0];
                    crc8pre_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            r_receiving    <= n_receiving;
            r_rx_count     <= n_rx_count;
            r_hdr_counter  <= n_hdr_counter;
            r_hdr_type     <= n_hdr_type;
            r_hdr_length   <= n_hdr_length;
            r_rx_crc       <= n_rx_crc;
            r_time_left    <= n_time_left;
            r_echo_pending <= n_echo_pending;
            r_tx_index     <= n_tx_index;
            r_tx_crc       <= n_tx_crc;
            if (in_fire) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_out <= res;
        end
    end

    a_echo_excludes_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_echo_pending |-> !r_receiving)
        else $error("echo pending while receiving");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_rx_count == 9'd0))
        else $error("rx count nonzero while hunting");

    a_last_is_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_last) |-> (r_out.event_res == crc8pre_pkg::EV_TX))
        else $error("tx_last on a non tx beat");

    a_busy_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.kind == crc8pre_pkg::KIND_RX_BYTE && r_echo_pending)
        |=> (r_out_valid && r_out.event_res == crc8pre_pkg::EV_BUSY))
        else $error("byte during echo not flagged busy");

    a_tx_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_echo_pending |-> (r_tx_index <= end_cnt))
        else $error("echo index past packet end");

endmodule

`default_nettype wire
